[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ZKL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ZKL_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ZKL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/zkl_pkg.sv]
`default_nettype none

package zkl_pkg;

  // Table layout
  localparam int PIECE_KINDS = 12;
  localparam int EP_BASE     = PIECE_KINDS * 64;
  localparam int CASTLE_BASE = EP_BASE + 8;
  localparam int SIDE_INDEX  = CASTLE_BASE + 16;
  localparam int TABLE_DEPTH = SIDE_INDEX + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Fixed field widths
  localparam int WORD_W   = 64;
  localparam int TIDX_W   = 10;
  localparam int PIECE_W  = 4;
  localparam int SQ_W     = 6;
  localparam int CASTLE_W = 4;

  typedef logic [IDX_W-1:0] tbl_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_PIECE     = 3'd2,
    OP_ENPASSANT = 3'd3,
    OP_CASTLING  = 3'd4,
    OP_SIDE      = 3'd5,
    OP_BITBOARD  = 3'd6,
    OP_READ      = 3'd7
  } opcode_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic wr_en;
    logic clr;
    logic rd_single;
    logic scan_en;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    piece_ok;
    logic    idx_ok;
    logic    btm;
    logic    scan_last;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/zkl_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module zkl_ctrl
  import zkl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Take an item only when idle and out of reset
  assign in_stall = (state_r != ST_IDLE) || !rst_n;

  // Sequence one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DRAIN;
        case (stat.op)
          OP_LOAD:      cmd.wr_en     = stat.idx_ok;
          OP_CLEAR:     cmd.clr       = 1'b1;
          OP_PIECE:     cmd.rd_single = stat.piece_ok;
          OP_ENPASSANT: cmd.rd_single = 1'b1;
          OP_CASTLING:  cmd.rd_single = 1'b1;
          OP_SIDE:      cmd.rd_single = stat.btm;
          OP_BITBOARD: begin
            if (stat.piece_ok) begin
              state_nxt = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ZKL_NEXT(a_accept_exec, in_valid && !in_stall, state_r == ST_EXEC, "accept did not start execution")
  `ZKL_NEXT(a_exec_once, state_r == ST_EXEC, state_r != ST_EXEC, "execute step repeated")
  `ZKL_NEXT(a_load_idle, cmd.out_load, state_r == ST_IDLE, "not idle after result load")

endmodule

`default_nettype wire

[design/zkl_dp.sv]
`default_nettype none

`include "assert_macros.svh"

module zkl_dp
  import zkl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  output dp_stat_t                 stat,
  input  wire logic [2:0]          in_opcode,
  input  wire logic [TIDX_W-1:0]   in_table_index,
  input  wire logic [WORD_W-1:0]   in_key_word,
  input  wire logic [WORD_W-1:0]   in_lock_word,
  input  wire logic [PIECE_W-1:0]  in_piece_kind,
  input  wire logic [SQ_W-1:0]     in_square,
  input  wire logic [CASTLE_W-1:0] in_castling_rights,
  input  wire logic                in_black_to_move,
  input  wire logic [WORD_W-1:0]   in_piece_bitboard,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        out_hash_key,
  output logic [WORD_W-1:0]        out_hash_lock
);

  // Lowest set bit of one byte
  function automatic logic [2:0] low_bit(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Captured item
  opcode_t             op_r;
  logic [TIDX_W-1:0]   tidx_r;
  logic [WORD_W-1:0]   kword_r, lword_r;
  logic [PIECE_W-1:0]  piece_r;
  logic [SQ_W-1:0]     sq_r;
  logic [CASTLE_W-1:0] castle_r;
  logic                btm_r;
  logic [WORD_W-1:0]   bb_r, bb_nxt;
  logic [2:0]          ptr_r, ptr_nxt;

  // Tables and read data
  logic [WORD_W-1:0] key_mem  [TABLE_DEPTH];
  logic [WORD_W-1:0] lock_mem [TABLE_DEPTH];
  logic [WORD_W-1:0] key_rd_r, lock_rd_r;
  logic              rd_pend_r;

  // Hashes and result register
  logic [WORD_W-1:0] key_acc_r, key_acc_nxt, lock_acc_r, lock_acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_key_r, out_lock_r;

  logic [7:0]  cur_byte, byte_clr;
  logic [2:0]  bit_sel;
  logic        byte_zero, one_left;
  logic        rd_en;
  tbl_idx_t    rd_addr, single_addr, scan_addr, wr_addr;

  // Scan the bitboard one byte window at a time
  assign cur_byte  = bb_r[{ptr_r, 3'b000} +: 8];
  assign byte_clr  = cur_byte & (cur_byte - 8'd1);
  assign byte_zero = (cur_byte == 8'd0);
  assign one_left  = (byte_clr == 8'd0);
  assign bit_sel   = low_bit(cur_byte);
  assign scan_addr = (tbl_idx_t'(piece_r) << 6) | tbl_idx_t'({ptr_r, bit_sel});

  always_comb begin
    bb_nxt  = bb_r;
    ptr_nxt = ptr_r;
    if (cmd.cap) begin
      bb_nxt  = in_piece_bitboard;
      ptr_nxt = '0;
    end else if (cmd.scan_en) begin
      bb_nxt[{ptr_r, 3'b000} +: 8] = byte_clr;
      if (byte_zero || one_left) ptr_nxt = ptr_r + 3'd1;
    end
  end

  // Pick the single-toggle entry
  always_comb begin
    case (op_r)
      OP_PIECE:     single_addr = (tbl_idx_t'(piece_r) << 6) | tbl_idx_t'(sq_r);
      OP_ENPASSANT: single_addr = tbl_idx_t'(EP_BASE) + tbl_idx_t'(sq_r[2:0]);
      OP_CASTLING:  single_addr = tbl_idx_t'(CASTLE_BASE) + tbl_idx_t'(castle_r);
      OP_SIDE:      single_addr = tbl_idx_t'(SIDE_INDEX);
      default:      single_addr = '0;
    endcase
  end

  assign rd_en   = cmd.rd_single || (cmd.scan_en && !byte_zero);
  assign rd_addr = cmd.scan_en ? scan_addr : single_addr;
  assign wr_addr = tbl_idx_t'(tidx_r);

  // Table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[wr_addr]  <= kword_r;
      lock_mem[wr_addr] <= lword_r;
    end
    if (rd_en) begin
      key_rd_r  <= key_mem[rd_addr];
      lock_rd_r <= lock_mem[rd_addr];
    end
  end

  // Fold read data into the hashes
  always_comb begin
    key_acc_nxt  = key_acc_r;
    lock_acc_nxt = lock_acc_r;
    if (cmd.clr) begin
      key_acc_nxt  = '0;
      lock_acc_nxt = '0;
    end else if (rd_pend_r) begin
      key_acc_nxt  = key_acc_r ^ key_rd_r;
      lock_acc_nxt = lock_acc_r ^ lock_rd_r;
    end
  end

  // Hold the result until taken
  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_acc_r   <= '0;
      lock_acc_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_acc_r   <= key_acc_nxt;
      lock_acc_r  <= lock_acc_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture item and payload
  always_ff @(posedge clk) begin
    bb_r  <= bb_nxt;
    ptr_r <= ptr_nxt;
    if (cmd.cap) begin
      op_r     <= opcode_t'(in_opcode);
      tidx_r   <= in_table_index;
      kword_r  <= in_key_word;
      lword_r  <= in_lock_word;
      piece_r  <= in_piece_kind;
      sq_r     <= in_square;
      castle_r <= in_castling_rights;
      btm_r    <= in_black_to_move;
    end
    if (cmd.out_load) begin
      out_key_r  <= key_acc_r;
      out_lock_r <= lock_acc_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.piece_ok  = (32'(piece_r) < 32'(PIECE_KINDS));
  assign stat.idx_ok    = (32'(tidx_r) < 32'(TABLE_DEPTH));
  assign stat.btm       = btm_r;
  assign stat.scan_last = (ptr_r == 3'd7) && (byte_zero || one_left);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_hash_key  = out_key_r;
  assign out_hash_lock = out_lock_r;

  `ZKL_IMPLY(a_no_clear_pending, rd_pend_r, !cmd.clr, "clear while read data pending")
  `ZKL_IMPLY(a_cap_quiet, cmd.cap, !rd_pend_r, "new item while read data pending")
  `ZKL_IMPLY(a_load_settled, cmd.out_load, !rd_pend_r && !rd_en, "result loaded before hashes settled")

endmodule

`default_nettype wire

[design/zobrist_key_lock_hasher_top.sv]
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | opcode, table_index, key/lock words,
//         |           |                   | piece_kind, square, castling_rights,
//         |           |                   | black_to_move, piece_bitboard
// out_    | output    | out_valid/out_stall | hash_key, hash_lock
//
// One item at a time: each is captured, executed, drained, then loaded as the result.
// A bitboard item with an in-range piece also scans its eight bytes, reading one table
// entry per set bit through the single table read port, one entry per cycle.
// rst_n (synchronous) clears both hashes; tables stay unknown until loaded.
// A result waiting under out_stall does not block the next item's acceptance.
`default_nettype none

module zobrist_key_lock_hasher_top
  import zkl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_opcode,
  input  wire logic [TIDX_W-1:0]   in_table_index,
  input  wire logic [WORD_W-1:0]   in_key_word,
  input  wire logic [WORD_W-1:0]   in_lock_word,
  input  wire logic [PIECE_W-1:0]  in_piece_kind,
  input  wire logic [SQ_W-1:0]     in_square,
  input  wire logic [CASTLE_W-1:0] in_castling_rights,
  input  wire logic                in_black_to_move,
  input  wire logic [WORD_W-1:0]   in_piece_bitboard,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        out_hash_key,
  output logic [WORD_W-1:0]        out_hash_lock
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  zkl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  zkl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_table_index     (in_table_index),
    .in_key_word        (in_key_word),
    .in_lock_word       (in_lock_word),
    .in_piece_kind      (in_piece_kind),
    .in_square          (in_square),
    .in_castling_rights (in_castling_rights),
    .in_black_to_move   (in_black_to_move),
    .in_piece_bitboard  (in_piece_bitboard),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hash_key       (out_hash_key),
    .out_hash_lock      (out_hash_lock)
  );

endmodule

`default_nettype wire

[test/tb_zobrist_key_lock_hasher_top.sv]
`timescale 1ns / 100ps

module tb_zobrist_key_lock_hasher_top;
  import zkl_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_TIDX     = (1 << TIDX_W) - 1;

  typedef struct packed {
    opcode_t               op;
    logic [TIDX_W-1:0]     tidx;
    logic [WORD_W-1:0]     key_word;
    logic [WORD_W-1:0]     lock_word;
    logic [PIECE_W-1:0]    piece;
    logic [SQ_W-1:0]       sq;
    logic [CASTLE_W-1:0]   rights;
    logic                  btm;
    logic [WORD_W-1:0]     board;
  } hash_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] lock;
  } hash_pair_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          in_opcode = '0;
  logic [TIDX_W-1:0]   in_table_index = '0;
  logic [WORD_W-1:0]   in_key_word = '0;
  logic [WORD_W-1:0]   in_lock_word = '0;
  logic [PIECE_W-1:0]  in_piece_kind = '0;
  logic [SQ_W-1:0]     in_square = '0;
  logic [CASTLE_W-1:0] in_castling_rights = '0;
  logic                in_black_to_move = 1'b0;
  logic [WORD_W-1:0]   in_piece_bitboard = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WORD_W-1:0]   out_hash_key;
  logic [WORD_W-1:0]   out_hash_lock;

  zobrist_key_lock_hasher_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_table_index     (in_table_index),
    .in_key_word        (in_key_word),
    .in_lock_word       (in_lock_word),
    .in_piece_kind      (in_piece_kind),
    .in_square          (in_square),
    .in_castling_rights (in_castling_rights),
    .in_black_to_move   (in_black_to_move),
    .in_piece_bitboard  (in_piece_bitboard),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hash_key       (out_hash_key),
    .out_hash_lock      (out_hash_lock)
  );

  always #2 clk = ~clk;

  // Position hash predictor: its own tables and running hashes
  logic [WORD_W-1:0] key_entry  [TABLE_DEPTH];
  logic [WORD_W-1:0] lock_entry [TABLE_DEPTH];
  logic [WORD_W-1:0] run_key  = '0;
  logic [WORD_W-1:0] run_lock = '0;
  int                squares_walked = 0;

  function automatic void fold_entry(input int idx);
    if (idx < TABLE_DEPTH) begin
      run_key  ^= key_entry[idx];
      run_lock ^= lock_entry[idx];
    end
  endfunction

  function automatic hash_pair_t advance_position_hash(input hash_item_t it);
    hash_pair_t res;
    case (it.op)
      OP_LOAD: begin
        if (it.tidx < TABLE_DEPTH) begin
          key_entry[it.tidx]  = it.key_word;
          lock_entry[it.tidx] = it.lock_word;
        end
      end
      OP_CLEAR: begin
        run_key  = '0;
        run_lock = '0;
      end
      OP_PIECE: begin
        if (it.piece < PIECE_KINDS) fold_entry(int'(it.piece) * 64 + int'(it.sq));
      end
      OP_ENPASSANT: fold_entry(EP_BASE + int'(it.sq[2:0]));
      OP_CASTLING:  fold_entry(CASTLE_BASE + int'(it.rights));
      OP_SIDE: begin
        if (it.btm) fold_entry(SIDE_INDEX);
      end
      OP_BITBOARD: begin
        if (it.piece < PIECE_KINDS) begin
          for (int s = 0; s < 64; s++) begin
            if (it.board[s]) begin
              fold_entry(int'(it.piece) * 64 + s);
              squares_walked++;
            end
          end
        end
      end
      default: ;
    endcase
    res.key  = run_key;
    res.lock = run_lock;
    return res;
  endfunction

  // Stimulus: items waiting to be offered, and which entries they have loaded
  hash_item_t pending_items[$];
  bit         entry_loaded [TABLE_DEPTH];
  int         n_directed;
  int         total_items;

  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic hash_item_t rand_item(input opcode_t op);
    hash_item_t it;
    it.op        = op;
    it.tidx      = TIDX_W'($urandom_range(0, MAX_TIDX));
    it.key_word  = rand_word();
    it.lock_word = rand_word();
    it.piece     = PIECE_W'($urandom_range(0, 15));
    it.sq        = SQ_W'($urandom_range(0, 63));
    it.rights    = CASTLE_W'($urandom_range(0, 15));
    it.btm       = 1'($urandom_range(0, 1));
    it.board     = {$urandom, $urandom};
    return it;
  endfunction

  task automatic queue_item(input hash_item_t it);
    if (it.op == OP_LOAD && it.tidx < TABLE_DEPTH) entry_loaded[it.tidx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic queue_load(input int idx);
    hash_item_t it;
    it      = rand_item(OP_LOAD);
    it.tidx = TIDX_W'(idx);
    queue_item(it);
  endtask

  // Toggles only touch loaded entries; a missing entry gets loaded instead
  task automatic queue_random_op(input opcode_t op);
    hash_item_t it;
    int         p;
    int         r;
    int         squares[$];
    it = rand_item(op);
    case (op)
      OP_LOAD: begin
        r = $urandom_range(0, 99);
        if (r < 10) it.tidx = TIDX_W'($urandom_range(TABLE_DEPTH, MAX_TIDX));
        else if (r < 25) it.tidx = TIDX_W'($urandom_range(EP_BASE, SIDE_INDEX));
        else it.tidx = TIDX_W'($urandom_range(0, EP_BASE - 1));
      end
      OP_PIECE, OP_BITBOARD: begin
        if ($urandom_range(0, 9) == 0) begin
          it.piece = PIECE_W'($urandom_range(PIECE_KINDS, 15));
        end else begin
          p = $urandom_range(0, PIECE_KINDS - 1);
          for (int s = 0; s < 64; s++) begin
            if (entry_loaded[p * 64 + s]) squares.push_back(s);
          end
          if (squares.size() == 0) begin
            queue_load(p * 64 + $urandom_range(0, 63));
            return;
          end
          it.piece = PIECE_W'(p);
          it.sq    = SQ_W'(squares[$urandom_range(0, squares.size() - 1)]);
          // mostly sparse boards, now and then empty or every loaded square
          r = $urandom_range(0, 19);
          it.board = '0;
          foreach (squares[i]) begin
            if (r == 0 || (r > 1 && $urandom_range(0, squares.size() - 1) < 6))
              it.board[squares[i]] = 1'b1;
          end
        end
      end
      OP_ENPASSANT: begin
        if (!entry_loaded[EP_BASE + it.sq[2:0]]) begin
          queue_load(EP_BASE + it.sq[2:0]);
          return;
        end
      end
      OP_CASTLING: begin
        if (!entry_loaded[CASTLE_BASE + it.rights]) begin
          queue_load(CASTLE_BASE + it.rights);
          return;
        end
      end
      OP_SIDE: begin
        if (it.btm && !entry_loaded[SIDE_INDEX]) begin
          queue_load(SIDE_INDEX);
          return;
        end
      end
      default: ;
    endcase
    queue_item(it);
  endtask

  task automatic build_directed();
    hash_item_t it;
    it = rand_item(OP_LOAD); it.tidx = 0; it.key_word = '1; it.lock_word = '0;
    queue_item(it);
    it = rand_item(OP_LOAD); it.tidx = TIDX_W'(EP_BASE - 1); it.key_word = '0;
    it.lock_word = '1;
    queue_item(it);
    queue_load(EP_BASE);
    queue_load(EP_BASE + 7);
    queue_load(CASTLE_BASE);
    queue_load(CASTLE_BASE + 15);
    queue_load(SIDE_INDEX);
    queue_load(MAX_TIDX);
    queue_load(TABLE_DEPTH);
    // single toggles at the corners, out-of-range pieces included
    it = rand_item(OP_PIECE); it.piece = 0; it.sq = 0; queue_item(it);
    it = rand_item(OP_PIECE); it.piece = PIECE_W'(PIECE_KINDS - 1); it.sq = '1;
    queue_item(it);
    it = rand_item(OP_PIECE); it.piece = PIECE_W'(PIECE_KINDS); it.sq = 0; queue_item(it);
    it = rand_item(OP_PIECE); it.piece = '1; it.sq = '1; queue_item(it);
    it = rand_item(OP_ENPASSANT); it.sq = 0; queue_item(it);
    it = rand_item(OP_ENPASSANT); it.sq = '1; queue_item(it);
    it = rand_item(OP_CASTLING); it.rights = 0; queue_item(it);
    it = rand_item(OP_CASTLING); it.rights = '1; queue_item(it);
    it = rand_item(OP_SIDE); it.btm = 1'b0; queue_item(it);
    it = rand_item(OP_SIDE); it.btm = 1'b1; queue_item(it);
    // bitboards: lowest square, highest square, empty, and out-of-range piece
    it = rand_item(OP_BITBOARD); it.piece = 0; it.board = 64'd1; queue_item(it);
    it = rand_item(OP_BITBOARD); it.piece = PIECE_W'(PIECE_KINDS - 1);
    it.board = 64'd1 << 63;
    queue_item(it);
    it = rand_item(OP_BITBOARD); it.piece = 0; it.board = '0; queue_item(it);
    it = rand_item(OP_BITBOARD); it.piece = '1; it.board = '1; queue_item(it);
    queue_item(rand_item(OP_READ));
    queue_item(rand_item(OP_CLEAR));
  endtask

  task automatic build_random();
    int      kind;
    int      len;
    int      p;
    int      r;
    opcode_t op;
    while (pending_items.size() < n_directed + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // fill tables: scattered entries or a whole rank of one piece
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(1, 12);
          repeat (len) queue_random_op(OP_LOAD);
        end else begin
          p = $urandom_range(0, PIECE_KINDS - 1) * 64 + $urandom_range(0, 7) * 8;
          for (int s = 0; s < 8; s++) queue_load(p + s);
        end
      end else if (kind < 85) begin
        // build a position from scratch or update the current one
        if ($urandom_range(0, 1) == 0) queue_item(rand_item(OP_CLEAR));
        len = $urandom_range(3, 12);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 35) op = OP_PIECE;
          else if (r < 60) op = OP_BITBOARD;
          else if (r < 72) op = OP_ENPASSANT;
          else if (r < 84) op = OP_CASTLING;
          else if (r < 96) op = OP_SIDE;
          else op = OP_READ;
          queue_random_op(op);
        end
        queue_item(rand_item(OP_READ));
      end else begin
        // noise: any operation at all
        len = $urandom_range(1, 4);
        repeat (len) queue_random_op(opcode_t'($urandom_range(0, 7)));
      end
    end
  endtask

  function automatic int pick_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: offer items from the pending queue, predict each accepted one
  hash_pair_t expected_hashes[$];
  hash_item_t offered;
  int         n_sent = 0;
  int         send_gap = 0;
  bit         send_calm = 1'b0;
  int         op_seen [8];

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_hashes.push_back(advance_position_hash(offered));
        op_seen[int'(offered.op)]++;
        n_sent++;
        if (n_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        offered = pending_items.pop_front();
        in_opcode          <= offered.op;
        in_table_index     <= offered.tidx;
        in_key_word        <= offered.key_word;
        in_lock_word       <= offered.lock_word;
        in_piece_kind      <= offered.piece;
        in_square          <= offered.sq;
        in_castling_rights <= offered.rights;
        in_black_to_move   <= offered.btm;
        in_piece_bitboard  <= offered.board;
        in_valid           <= 1'b1;
        send_gap = pick_pause(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  int n_checked = 0;
  int n_errors = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin
    hash_pair_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected result key %h lock %h", $time, out_hash_key,
                   out_hash_lock);
          n_errors++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_hash_key !== want.key) begin
            $display("%0t: hash_key expected %h got %h", $time, want.key, out_hash_key);
            n_errors++;
          end
          if (out_hash_lock !== want.lock) begin
            $display("%0t: hash_lock expected %h got %h", $time, want.lock, out_hash_lock);
            n_errors++;
          end
          n_checked++;
          if (n_checked % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        end
      end
      // hold off once for a long stretch so the block backs up its input
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
        stall_left = pick_pause(1'b0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items sent, %0d results outstanding", $time,
               n_sent, expected_hashes.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    build_directed();
    n_directed = pending_items.size();
    build_random();
    total_items = pending_items.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (!(n_sent == total_items && expected_hashes.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d loads, %0d clears, %0d piece, %0d en-passant,",
             n_sent, op_seen[OP_LOAD], op_seen[OP_CLEAR], op_seen[OP_PIECE],
             op_seen[OP_ENPASSANT]);
    $display("  %0d castling, %0d side, %0d bitboard (%0d squares), %0d read; %0d results",
             op_seen[OP_CASTLING], op_seen[OP_SIDE], op_seen[OP_BITBOARD], squares_walked,
             op_seen[OP_READ], n_checked);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/zkl_pkg.sv
design/zkl_ctrl.sv
design/zkl_dp.sv
design/zobrist_key_lock_hasher_top.sv
test/tb_zobrist_key_lock_hasher_top.sv
